>>> rtl/cft_pkg.sv
package cft_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int LEN_W    = 10;
  localparam int FLEN_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELDS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELD_LEN = 2'd2;

  localparam logic [BYTE_W-1:0]  SEPARATOR_RST     = 8'd59;
  localparam logic [COUNT_W-1:0] MAX_FIELDS_RST    = 8'd100;
  localparam logic [FLEN_W-1:0]  MAX_FIELD_LEN_RST = 11'd1024;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  // longest field that the length counter can hold
  localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};

  // parse modes
  localparam logic [2:0] M_START  = 3'd0;
  localparam logic [2:0] M_PLAIN  = 3'd1;
  localparam logic [2:0] M_QUOTED = 3'd2;
  localparam logic [2:0] M_QSEEN  = 3'd3;
  localparam logic [2:0] M_DONE   = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0]  separator;
    logic [COUNT_W-1:0] max_fields;
    logic [FLEN_W-1:0]  max_field_len;
  } cfg_t;

  typedef struct packed {
    logic               char_valid;
    logic [BYTE_W-1:0]  char_out;
    logic               field_end;
    logic [COUNT_W-1:0] field_index;
    logic [LEN_W-1:0]   field_length;
    logic               row_end;
    logic [COUNT_W-1:0] field_count;
  } res_t;

endpackage

>>> rtl/cft_if.sv
interface cft_in_if;
  import cft_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              line_end;
  modport source (output valid, output data_byte, output line_end, input ready);
  modport sink (input valid, input data_byte, input line_end, output ready);
endinterface

interface cft_out_if;
  import cft_pkg::*;
  logic               valid;
  logic               ready;
  logic               char_valid;
  logic [BYTE_W-1:0]  char_out;
  logic               field_end;
  logic [COUNT_W-1:0] field_index;
  logic [LEN_W-1:0]   field_length;
  logic               row_end;
  logic [COUNT_W-1:0] field_count;
  modport source (
    output valid, output char_valid, output char_out, output field_end,
    output field_index, output field_length, output row_end, output field_count,
    input ready
  );
  modport sink (
    input valid, input char_valid, input char_out, input field_end,
    input field_index, input field_length, input row_end, input field_count,
    output ready
  );
endinterface

interface cft_cfg_if;
  import cft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/cft_cfg_regs.sv
module cft_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [cft_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [cft_pkg::CFG_DAT_W-1:0] wr_data,
  output cft_pkg::cfg_t                 cfg
);
  import cft_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator     <= SEPARATOR_RST;
      cfg_r.max_fields    <= MAX_FIELDS_RST;
      cfg_r.max_field_len <= MAX_FIELD_LEN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SEPARATOR:     cfg_r.separator     <= wr_data[BYTE_W-1:0];
        REG_MAX_FIELDS:    cfg_r.max_fields    <= wr_data[COUNT_W-1:0];
        REG_MAX_FIELD_LEN: cfg_r.max_field_len <= wr_data[FLEN_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/cft_parser.sv
module cft_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cft_pkg::cfg_t              cfg,
  input  logic                       in_fire,
  input  logic [cft_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_term,
  output cft_pkg::res_t              res,
  output logic [2:0]                 mode
);
  import cft_pkg::*;

  logic [2:0]         mode_r, mode_nxt;
  logic [COUNT_W-1:0] fields_r, fields_nxt;
  logic [LEN_W-1:0]   kept_r, kept_nxt;

  logic [LEN_W-1:0]   limit;
  logic [FLEN_W-1:0]  len_m1;
  logic [COUNT_W-1:0] fields_inc;
  logic               room;
  logic               is_sep, is_quote, is_eol;

  assign len_m1 = cfg.max_field_len - FLEN_W'(1);

  always_comb begin
    if (cfg.max_field_len == '0) begin
      limit = '0;
    end else if (len_m1 > FLEN_W'(LEN_CAP)) begin
      limit = LEN_CAP;
    end else begin
      limit = len_m1[LEN_W-1:0];
    end
  end

  assign room       = kept_r < limit;
  assign fields_inc = fields_r + COUNT_W'(1);
  assign is_sep     = in_byte == cfg.separator;
  assign is_quote   = in_byte == CH_QUOTE;
  assign is_eol     = (in_byte == CH_CR) || (in_byte == CH_LF);

  always_comb begin
    logic keep, close, forced, row_only;
    logic [BYTE_W-1:0] kchar;
    keep     = 1'b0;
    close    = 1'b0;
    forced   = 1'b0;
    row_only = 1'b0;
    kchar    = in_byte;
    res      = '0;
    mode_nxt   = mode_r;
    fields_nxt = fields_r;
    kept_nxt   = kept_r;

    if (in_term) begin
      unique case (mode_r)
        M_START:                    row_only = 1'b1;
        M_PLAIN, M_QUOTED, M_QSEEN: begin
          close  = 1'b1;
          forced = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_r)
        M_START: begin
          priority if (is_eol || fields_r >= cfg.max_fields) begin
            row_only = 1'b1;
          end else if (is_quote) begin
            mode_nxt = M_QUOTED;
          end else if (is_sep) begin
            close = 1'b1;
          end else begin
            mode_nxt = M_PLAIN;
            keep     = 1'b1;
          end
        end
        M_PLAIN: begin
          priority if (is_sep) begin
            close = 1'b1;
          end else if (is_eol) begin
            close  = 1'b1;
            forced = 1'b1;
          end else begin
            keep = 1'b1;
          end
        end
        M_QUOTED: begin
          if (is_quote) mode_nxt = M_QSEEN;
          else          keep = 1'b1;
        end
        M_QSEEN: begin
          priority if (is_quote) begin
            mode_nxt = M_QUOTED;
            keep     = 1'b1;
            kchar    = CH_QUOTE;
          end else if (is_sep) begin
            close = 1'b1;
          end else begin
            close  = 1'b1;
            forced = 1'b1;
          end
        end
        default: ;  // row done: swallow the byte
      endcase
    end

    // over-long field: drop the byte
    if (keep && room) begin
      res.char_valid  = 1'b1;
      res.char_out    = kchar;
      res.field_index = fields_r;
      kept_nxt        = kept_r + LEN_W'(1);
    end

    if (close) begin
      res.field_end    = 1'b1;
      res.field_index  = fields_r;
      res.field_length = kept_r;
      kept_nxt         = '0;
      fields_nxt       = fields_inc;
      if (forced || fields_inc >= cfg.max_fields) begin
        res.row_end     = 1'b1;
        res.field_count = fields_inc;
        mode_nxt        = M_DONE;
      end else begin
        mode_nxt = M_START;
      end
    end

    if (row_only) begin
      res.row_end     = 1'b1;
      res.field_count = fields_r;
      mode_nxt        = M_DONE;
    end

    // terminator starts a fresh line
    if (in_term) begin
      mode_nxt   = M_START;
      fields_nxt = '0;
      kept_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      fields_r <= '0;
      kept_r   <= '0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      fields_r <= fields_nxt;
      kept_r   <= kept_nxt;
    end
  end

  assign mode = mode_r;

endmodule

>>> rtl/cft_skid.sv
module cft_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  cft_pkg::res_t in_res,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cft_pkg::res_t out_res,
  output logic          skid_valid
);
  import cft_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_res_r, skid_res_r;
  logic out_fire;

  assign out_fire = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_res_r <= skid_res_r;
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) skid_res_r <= in_res;
      else                           out_res_r  <= in_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;
  assign skid_valid = skid_valid_r;

endmodule

>>> rtl/csv_field_tokenizer.sv
// CSV field tokenizer: splits a line of CSV text, one byte per input beat,
// into field characters with field and row end marks.
// in_ch  : data_byte plus line_end; a beat with line_end set closes the line.
// out_ch : exactly one result beat per input beat, in order (an all-zero
//          result where the byte carries nothing to report).
// cfg_ch : register writes (0 separator, 1 max_fields, 2 max_field_len),
//          always ready, applied at the handshake edge; write only when idle.
// Throughput is one byte per cycle while the receiver keeps up: the parse
// state is a small FSM updated in the cycle a beat is taken, and its result
// goes straight into the output register.
// When the receiver stalls, a one-entry skid buffer takes one more beat and
// in_ch.ready then drops until the receiver takes the waiting result beat.
// Synchronous reset (rst_n low) restores register defaults, returns the
// parser to the start of a row and empties the output stage.
module csv_field_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  cft_in_if.sink     in_ch,
  cft_out_if.source  out_ch,
  cft_cfg_if.sink    cfg_ch
);
  import cft_pkg::*;

  cfg_t       cfg;
  res_t       res, out_res;
  logic       in_fire, in_ready, skid_valid;
  logic [2:0] mode;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;

  cft_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  cft_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_fire (in_fire),
    .in_byte (in_ch.data_byte),
    .in_term (in_ch.line_end),
    .res     (res),
    .mode    (mode)
  );

  cft_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_res     (res),
    .in_ready   (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_res),
    .skid_valid (skid_valid)
  );

  assign out_ch.char_valid   = out_res.char_valid;
  assign out_ch.char_out     = out_res.char_out;
  assign out_ch.field_end    = out_res.field_end;
  assign out_ch.field_index  = out_res.field_index;
  assign out_ch.field_length = out_res.field_length;
  assign out_ch.row_end      = out_res.row_end;
  assign out_ch.field_count  = out_res.field_count;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid |-> out_ch.valid)
    else $error("skid holds a beat while the output register is empty");

  a_char_or_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !(res.char_valid && res.field_end))
    else $error("character and field end in one result");

  a_row_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.line_end && res.row_end) |=> (mode == M_DONE))
    else $error("row end without entering row done");

endmodule

>>> sim/csv_field_tokenizer_checker.sv
`timescale 1ns / 100ps
module csv_field_tokenizer_checker (
  input  logic clk,
  input  logic rst_n,
  cft_in_if    in_ch,
  cft_out_if   out_ch,
  cft_cfg_if   cfg_ch,
  output int   fail_count,
  output int   outstanding
);
  import cft_pkg::*;

  // register copies
  logic [BYTE_W-1:0]  sep_byte;
  logic [COUNT_W-1:0] field_cap;
  logic [FLEN_W-1:0]  len_limit_cfg;

  // parser copy
  logic [2:0]         scan_mode;
  logic [COUNT_W-1:0] field_no;
  logic [LEN_W-1:0]   kept_len;

  res_t expected_tokens[$];
  int   result_no;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    result_no   = 0;
  end

  task automatic flag_error(input string what, input int got_v, input int want_v);
    $display("%0t: result %0d, %s: got %0d, want %0d",
             $time, result_no, what, got_v, want_v);
    fail_count++;
  endtask

  function automatic void store_char(input logic [BYTE_W-1:0] c, inout res_t r);
    logic [FLEN_W-1:0] keep_max;
    keep_max = (len_limit_cfg == '0) ? '0 : len_limit_cfg - 1'b1;
    if (keep_max > {1'b0, LEN_CAP})
      keep_max = {1'b0, LEN_CAP};
    if ({1'b0, kept_len} < keep_max) begin
      kept_len     = kept_len + 1'b1;
      r.char_valid = 1'b1;
      r.char_out   = c;
      r.field_index = field_no;
    end
  endfunction

  function automatic void finish_row(inout res_t r);
    r.row_end     = 1'b1;
    r.field_count = field_no;
    scan_mode     = M_DONE;
  endfunction

  function automatic void finish_field(inout res_t r, input logic forced);
    r.field_end    = 1'b1;
    r.field_index  = field_no;
    r.field_length = kept_len;
    kept_len       = '0;
    field_no       = field_no + 1'b1;
    if (forced || field_no >= field_cap)
      finish_row(r);
    else
      scan_mode = M_START;
  endfunction

  function automatic res_t tokenize_byte(input logic [BYTE_W-1:0] b, input logic term);
    res_t r;
    r = '0;
    if (term) begin
      case (scan_mode)
        M_START: finish_row(r);
        M_PLAIN, M_QUOTED, M_QSEEN: finish_field(r, 1'b1);
        default: ;
      endcase
      scan_mode = M_START;
      field_no  = '0;
      kept_len  = '0;
    end else begin
      case (scan_mode)
        M_START: begin
          if (b == CH_CR || b == CH_LF || field_no >= field_cap)
            finish_row(r);
          else if (b == CH_QUOTE)
            scan_mode = M_QUOTED;
          else if (b == sep_byte)
            finish_field(r, 1'b0);
          else begin
            scan_mode = M_PLAIN;
            store_char(b, r);
          end
        end
        M_PLAIN: begin
          if (b == sep_byte)
            finish_field(r, 1'b0);
          else if (b == CH_CR || b == CH_LF)
            finish_field(r, 1'b1);
          else
            store_char(b, r);
        end
        M_QUOTED: begin
          if (b == CH_QUOTE)
            scan_mode = M_QSEEN;
          else
            store_char(b, r);
        end
        M_QSEEN: begin
          // doubled quote goes back inside; anything else closes the field
          if (b == CH_QUOTE) begin
            scan_mode = M_QUOTED;
            store_char(CH_QUOTE, r);
          end else if (b == sep_byte)
            finish_field(r, 1'b0);
          else
            finish_field(r, 1'b1);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      sep_byte      = SEPARATOR_RST;
      field_cap     = MAX_FIELDS_RST;
      len_limit_cfg = MAX_FIELD_LEN_RST;
      scan_mode     = M_START;
      field_no      = '0;
      kept_len      = '0;
      expected_tokens.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SEPARATOR:     sep_byte = cfg_ch.data[BYTE_W-1:0];
          REG_MAX_FIELDS:    field_cap = cfg_ch.data[COUNT_W-1:0];
          REG_MAX_FIELD_LEN: len_limit_cfg = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_tokens.push_back(tokenize_byte(in_ch.data_byte, in_ch.line_end));
      if (out_ch.valid && out_ch.ready) begin
        result_no++;
        if (expected_tokens.size() == 0)
          flag_error("beat with nothing expected", 1, 0);
        else begin
          want = expected_tokens.pop_front();
          if (out_ch.char_valid !== want.char_valid)
            flag_error("char_valid", int'(out_ch.char_valid), int'(want.char_valid));
          if (out_ch.char_out !== want.char_out)
            flag_error("char_out", int'(out_ch.char_out), int'(want.char_out));
          if (out_ch.field_end !== want.field_end)
            flag_error("field_end", int'(out_ch.field_end), int'(want.field_end));
          if (out_ch.field_index !== want.field_index)
            flag_error("field_index", int'(out_ch.field_index), int'(want.field_index));
          if (out_ch.field_length !== want.field_length)
            flag_error("field_length", int'(out_ch.field_length),
                       int'(want.field_length));
          if (out_ch.row_end !== want.row_end)
            flag_error("row_end", int'(out_ch.row_end), int'(want.row_end));
          if (out_ch.field_count !== want.field_count)
            flag_error("field_count", int'(out_ch.field_count), int'(want.field_count));
        end
      end
    end
    outstanding = expected_tokens.size();
  end

endmodule

>>> sim/csv_field_tokenizer_test.sv
`timescale 1ns / 100ps
module csv_field_tokenizer_test;
  import cft_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 32;

  logic clk;
  logic rst_n;
  logic calm;
  logic holdoff;
  int   beats_sent;
  int   fail_count;
  int   outstanding;
  logic [BYTE_W-1:0] cur_sep;

  cft_in_if  in_ch ();
  cft_out_if out_ch ();
  cft_cfg_if cfg_ch ();

  csv_field_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  csv_field_tokenizer_checker token_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, none while calm, solid stall during the hold-off
  always @(negedge clk) begin
    if (holdoff)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 23);
  end

  // hold the output off long enough for the input to back up
  initial begin
    holdoff = 1'b0;
    wait (beats_sent >= 400);
    @(negedge clk);
    holdoff <= 1'b1;
    repeat (64) @(negedge clk);
    holdoff <= 1'b0;
  end

  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic le);
    while (!calm && !holdoff && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.line_end  <= le;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [BYTE_W-1:0] text_byte();
    if ($urandom_range(0, 3) != 0)
      return BYTE_W'($urandom_range(8'h61, 8'h7A));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain, let the pipe settle, then rewrite all three registers
  task automatic program_regs(input logic [BYTE_W-1:0] sep, input logic [COUNT_W-1:0] fmax,
                              input logic [FLEN_W-1:0] flen);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    write_reg(REG_SEPARATOR, {{(CFG_DAT_W-BYTE_W){1'b0}}, sep});
    write_reg(REG_MAX_FIELDS, {{(CFG_DAT_W-COUNT_W){1'b0}}, fmax});
    write_reg(REG_MAX_FIELD_LEN, flen);
    cfg_ch.valid <= 1'b0;
    cur_sep = sep;
  endtask

  initial begin : stimulus
    int phase_start;
    rst_n           = 1'b0;
    calm            = 1'b0;
    beats_sent      = 0;
    cur_sep         = SEPARATOR_RST;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.line_end  = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_SEPARATOR;
    cfg_ch.data     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_regs(SEPARATOR_RST, MAX_FIELDS_RST, MAX_FIELD_LEN_RST);

    // directed lines with the default semicolon separator
    send_end();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text(";");
    send_text("\"a;");
    send_beat(CH_CR, 1'b0);
    send_beat(CH_LF, 1'b0);
    send_text("\"\"b\"x");          // byte after the closing quote ends the row
    send_text("z");                  // after row end: nothing to report
    send_end();
    send_text("\"q");                // line closes inside an open quoted field
    send_end();
    send_text("\"e\";f");
    send_beat(CH_CR, 1'b0);
    send_end();
    send_text("c;");                 // trailing separator opens no field
    send_beat(CH_LF, 1'b0);
    send_end();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(SEPARATOR_RST, MAX_FIELDS_RST, MAX_FIELD_LEN_RST);
        1: program_regs(8'h2C, 8'd3, 11'd4);
        2: program_regs(CH_QUOTE, 8'd255, 11'd1);
        3: program_regs(CH_CR, 8'd1, 11'd2);
        4: program_regs(CH_LF, 8'd5, 11'd1024);
        5: program_regs(8'h00, 8'd2, 11'd8);
        6: program_regs(8'hFF, 8'd255, 11'd3);
        default: program_regs(BYTE_W'($urandom_range(0, 255)),
                              COUNT_W'($urandom_range(1, 255)),
                              FLEN_W'($urandom_range(1, 1024)));
      endcase
      calm <= (ph == 0);
      phase_start = beats_sent;

      // one field past the length counter, one row past the field limit
      if (ph == 0) begin
        repeat (1030) send_beat(BYTE_W'($urandom_range(8'h61, 8'h7A)), 1'b0);
        send_end();
      end
      if (ph == 6) begin
        repeat (260) send_beat(cur_sep, 1'b0);
        send_end();
      end

      while (beats_sent - phase_start < PHASE_BEATS) begin : one_line
        int kind;
        int nf;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
          repeat ($urandom_range(1, 12))
            send_beat(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if (kind < 12) begin
          repeat ($urandom_range(1, 40)) send_beat(cur_sep, 1'b0);
          send_end();
        end else begin
          nf = $urandom_range(1, 6);
          for (int f = 0; f < nf; f++) begin
            if (f != 0)
              send_beat(cur_sep, 1'b0);
            if ($urandom_range(0, 2) == 0) begin
              send_beat(CH_QUOTE, 1'b0);
              repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 9))
                  0: send_beat(cur_sep, 1'b0);
                  1: send_beat(CH_CR, 1'b0);
                  2: send_beat(CH_LF, 1'b0);
                  3: begin
                    send_beat(CH_QUOTE, 1'b0);
                    send_beat(CH_QUOTE, 1'b0);
                  end
                  default: send_beat(text_byte(), 1'b0);
                endcase
              end
              send_beat(CH_QUOTE, 1'b0);
            end else begin
              repeat ($urandom_range(0, 5)) send_beat(text_byte(), 1'b0);
            end
          end
          case ($urandom_range(0, 5))
            0: send_beat(CH_CR, 1'b0);
            1: send_beat(CH_LF, 1'b0);
            2: begin
              send_beat(CH_CR, 1'b0);
              send_beat(CH_LF, 1'b0);
            end
            3: ;
            4: send_beat(cur_sep, 1'b0);
            default: send_beat(text_byte(), 1'b0);
          endcase
          if ($urandom_range(0, 7) != 0)
            send_end();
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
